// ===== rtl/core/lpfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfd_pkg
// shared types and constants of the length-prefixed frame decoder
// ----------------------------------------------------------------------------
package lpfd_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned FieldW = 15;

    // reset value of the payload length limit
    localparam logic [FieldW-1:0] MaxLenReset = 15'd2048;

    typedef logic [ByteW-1:0]  t_byte;
    typedef logic [FieldW-1:0] t_field;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind  kind;
        t_field frame_id;
        t_field frame_len;
        t_byte  data_byte;
        logic   last;
    } t_result;

endpackage

// ===== rtl/core/lpfd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfd_in_if / lpfd_out_if
// valid/ready channels for the received bytes and the decoded results
// ----------------------------------------------------------------------------
interface lpfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface lpfd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [14:0] frame_id;
    logic [14:0] frame_len;
    logic [7:0]  data_byte;
    logic        last;

    modport source (output valid, output kind, output frame_id, output frame_len,
                    output data_byte, output last, input ready);
    modport sink   (input valid, input kind, input frame_id, input frame_len,
                    input data_byte, input last, output ready);
endinterface

// ===== rtl/core/length_prefixed_frame_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_frame_decoder_unit
// byte-stream decoder for frames with a 4-byte id/length header
// ----------------------------------------------------------------------------
// Takes one word (a byte) per clock while the result register is free. A frame is a big-endian 16-bit id, a
// big-endian 16-bit length and then that many payload bytes. Header words
// give no result; each payload word gives one result (kind 0) with the id
// and length, last set on the final one; a zero-length header gives one
// kind 1 result with last set. A header whose id or length has bit 15 set,
// or whose length exceeds r_max_len, gives one kind 2 result and the
// block then drops every word until reset. Throughput is one word per clock
// with no bubbles while o_out.ready stays high; a result is loaded into the
// result register when its word leaves the input register (input register at
// the accepting edge, result register when the word is decoded). r_max_len
// is read when the fourth header word leaves the input register.
// ----------------------------------------------------------------------------
module length_prefixed_frame_decoder_unit
    import lpfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [14:0] i_cfg_wdata,
    lpfd_in_if.sink     i_in,
    lpfd_out_if.source  o_out
);

    // length limit register
    t_field  r_max_len;

    // input register
    logic    r_in_valid;
    t_byte   r_in_byte;

    // pipeline control
    logic    step;       // input register word is decoded this cycle
    logic    out_free;   // result register can take a new result
    logic    res_valid;  // decoded word produces a result
    t_result res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MaxLenReset;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_wdata;
        end
    end

    // advance whenever the result slot is free, even for silent words
    assign step       = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.byte_in;
        end
    end

    // header check and payload count
    lpfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .i_max_len   (r_max_len),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register
    lpfd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .o_out   (o_out)
    );

endmodule

// ===== rtl/core/lpfd_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfd_parser
// header collection, header check and payload count for one word per step
// ----------------------------------------------------------------------------
module lpfd_parser
    import lpfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_byte   i_byte,
    input  t_field  i_max_len,
    output logic    o_res_valid,
    output t_result o_res
);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_ERROR   = 2'd2
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_hdr_idx, n_hdr_idx;
    logic [15:0] r_held_id, n_held_id;
    logic [15:0] r_held_len, n_held_len;
    t_field      r_left, n_left;
    logic        bad;

    always_comb begin
        n_phase     = r_phase;
        n_hdr_idx   = r_hdr_idx;
        n_held_id   = r_held_id;
        n_held_len  = r_held_len;
        n_left      = r_left;
        o_res_valid = 1'b0;
        bad         = 1'b0;
        o_res.kind      = KIND_BYTE;
        o_res.frame_id  = r_held_id[FieldW-1:0];
        o_res.frame_len = r_held_len[FieldW-1:0];
        o_res.data_byte = '0;
        o_res.last      = 1'b0;

        unique case (r_phase)
            PH_ERROR: begin
                // sticky: drop every word
            end
            PH_PAYLOAD: begin
                o_res_valid     = 1'b1;
                o_res.data_byte = i_byte;
                o_res.last      = (r_left == t_field'(1));
                n_left          = r_left - t_field'(1);
                if (r_left == t_field'(1)) begin
                    n_phase = PH_HEADER;
                end
            end
            default: begin
                unique case (r_hdr_idx)
                    2'd0: n_held_id  = {i_byte, 8'h00};
                    2'd1: n_held_id  = {r_held_id[15:8], i_byte};
                    2'd2: n_held_len = {i_byte, 8'h00};
                    2'd3: n_held_len = {r_held_len[15:8], i_byte};
                    default: n_held_len = r_held_len;
                endcase
                n_hdr_idx = r_hdr_idx + 2'd1;
                o_res.frame_id  = n_held_id[FieldW-1:0];
                o_res.frame_len = n_held_len[FieldW-1:0];
                if (r_hdr_idx == 2'd3) begin
                    bad = n_held_id[15] || n_held_len[15] ||
                          (n_held_len[FieldW-1:0] > i_max_len);
                    o_res_valid = bad || (n_held_len == 16'd0);
                    if (bad) begin
                        n_phase    = PH_ERROR;
                        o_res.kind = KIND_ERROR;
                    end else if (n_held_len == 16'd0) begin
                        n_phase    = PH_HEADER;
                        o_res.kind = KIND_EMPTY;
                        o_res.last = 1'b1;
                    end else begin
                        n_phase = PH_PAYLOAD;
                        n_left  = n_held_len[FieldW-1:0];
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_hdr_idx  <= 2'd0;
            r_held_id  <= '0;
            r_held_len <= '0;
            r_left     <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_hdr_idx  <= n_hdr_idx;
            r_held_id  <= n_held_id;
            r_held_len <= n_held_len;
            r_left     <= n_left;
        end
    end

endmodule

// ===== rtl/core/lpfd_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfd_out_reg
// result register that drives the output channel
// ----------------------------------------------------------------------------
module lpfd_out_reg
    import lpfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_result     i_res,
    output logic        o_free,
    lpfd_out_if.source  o_out
);

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    assign o_free  = !r_valid || o_out.ready;
    assign n_valid = i_load ? 1'b1 : (o_out.ready ? 1'b0 : r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.kind      = r_res.kind;
    assign o_out.frame_id  = r_res.frame_id;
    assign o_out.frame_len = r_res.frame_len;
    assign o_out.data_byte = r_res.data_byte;
    assign o_out.last      = r_res.last;

endmodule
